// ===== sv/qspd_pkg.sv =====
// Shared types, character codes and helpers for the query string decoder.
`timescale 1ns / 1ps

package qspd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Escape progress
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    // Results one request can cause, and the result queue
    localparam int MAX_RES    = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       out_run_end;
    } t_out;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h61 + 8'd10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h41 + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic t_out mk_res(input logic [1:0] kind, input logic [7:0] b);
        t_out r;
        r.out_byte    = b;
        r.out_kind    = kind;
        r.out_run_end = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/query_string_percent_decoder.sv =====
// Top level of the query string decoder: byte parser and result queue.
`timescale 1ns / 1ps
// Results are registered in the result queue and offered in order from its head.
// Throughput: one request per cycle while each causes at most one result and i_stall
//   is low; a request causing two or three results holds input stall high until the
//   four-entry queue, draining one result per cycle while i_stall is low, holds one.
// Reset: synchronous, active low; clears parse state and empties the result queue.
module query_string_percent_decoder
    import qspd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // request side
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_in,
    // result side
    output logic o_valid,
    input  logic i_stall,
    output t_out o_out
);

    // ---------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------
    logic       r_vp, n_vp;     // in the value part of the pair
    logic       r_ps, n_ps;     // pair has seen at least one byte
    logic [1:0] r_pc, n_pc;     // escape progress
    logic [7:0] r_pd, n_pd;     // byte held after '%'

    // ---------------------------------------------------------------
    // Result queue: small register ring, one read port at the head
    // ---------------------------------------------------------------
    t_out              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    t_out       w_res [MAX_RES];
    logic [1:0] w_cnt;          // results caused by the current request
    logic       w_acc;          // request accepted this cycle
    logic       w_pop;          // result taken this cycle

    // Accept only while three free slots are guaranteed, ignoring the pop,
    // so input stall never depends on output stall.
    assign o_stall = (r_count > QCNT_W'(QDEPTH - MAX_RES));
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;
    assign o_out   = r_q[r_rd_ptr];

    // ---------------------------------------------------------------
    // Decode one byte: emits are appended to w_res in order
    // ---------------------------------------------------------------
    always_comb begin
        n_vp  = r_vp;
        n_ps  = r_ps;
        n_pc  = r_pc;
        n_pd  = r_pd;
        w_cnt = 2'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            w_res[k] = '0;
        end

        if (i_in.in_byte == CH_AMP) begin
            // close the pair: leftover escape goes out literally
            if (n_pc != PEND_NONE) begin
                w_res[w_cnt] = mk_res(n_vp ? KIND_VALUE : KIND_KEY, CH_PERCENT);
                w_cnt        = w_cnt + 2'd1;
            end
            if (n_pc != PEND_NONE && n_pc != PEND_PCT) begin
                w_res[w_cnt] = mk_res(n_vp ? KIND_VALUE : KIND_KEY, plain_byte(n_pd));
                w_cnt        = w_cnt + 2'd1;
            end
            if (n_ps) begin
                w_res[w_cnt] = mk_res(KIND_END, 8'd0);
                w_cnt        = w_cnt + 2'd1;
            end
            n_pc = PEND_NONE;
            n_pd = 8'd0;
            n_vp = 1'b0;
            n_ps = 1'b0;
        end else begin
            n_ps = 1'b1;
            if (i_in.in_byte == CH_EQUALS && !n_vp) begin
                // key ends: flush any partial escape into the key
                if (n_pc != PEND_NONE) begin
                    w_res[w_cnt] = mk_res(KIND_KEY, CH_PERCENT);
                    w_cnt        = w_cnt + 2'd1;
                end
                if (n_pc != PEND_NONE && n_pc != PEND_PCT) begin
                    w_res[w_cnt] = mk_res(KIND_KEY, plain_byte(n_pd));
                    w_cnt        = w_cnt + 2'd1;
                end
                n_pc = PEND_NONE;
                n_pd = 8'd0;
                n_vp = 1'b1;
            end else if (n_pc == PEND_NONE) begin
                if (i_in.in_byte == CH_PERCENT) begin
                    n_pc = PEND_PCT;
                end else begin
                    w_res[w_cnt] = mk_res(n_vp ? KIND_VALUE : KIND_KEY,
                                          plain_byte(i_in.in_byte));
                    w_cnt        = w_cnt + 2'd1;
                end
            end else if (n_pc == PEND_PCT) begin
                n_pd = i_in.in_byte;
                n_pc = PEND_DIGIT;
            end else begin
                // second digit: combine high and low nibbles
                w_res[w_cnt] = mk_res(n_vp ? KIND_VALUE : KIND_KEY,
                                      {hex_val(n_pd), hex_val(i_in.in_byte)});
                w_cnt        = w_cnt + 2'd1;
                n_pc = PEND_NONE;
                n_pd = 8'd0;
            end

            if (i_in.in_final) begin
                // end of string closes the pair as '&' would
                if (n_pc != PEND_NONE) begin
                    w_res[w_cnt] = mk_res(n_vp ? KIND_VALUE : KIND_KEY, CH_PERCENT);
                    w_cnt        = w_cnt + 2'd1;
                end
                if (n_pc != PEND_NONE && n_pc != PEND_PCT) begin
                    w_res[w_cnt] = mk_res(n_vp ? KIND_VALUE : KIND_KEY, plain_byte(n_pd));
                    w_cnt        = w_cnt + 2'd1;
                end
                w_res[w_cnt] = mk_res(KIND_END, 8'd0);
                w_cnt        = w_cnt + 2'd1;
            end
        end

        if (i_in.in_final) begin
            n_vp = 1'b0;
            n_ps = 1'b0;
            n_pc = PEND_NONE;
            n_pd = 8'd0;
        end

        // mark the last result of this request
        if (w_cnt != 2'd0) begin
            w_res[w_cnt - 2'd1].out_run_end = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp     <= 1'b0;
            r_ps     <= 1'b0;
            r_pc     <= PEND_NONE;
            r_pd     <= 8'd0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_acc) begin
                r_vp     <= n_vp;
                r_ps     <= n_ps;
                r_pc     <= n_pc;
                r_pd     <= n_pd;
                r_wr_ptr <= r_wr_ptr + QPTR_W'(w_cnt);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (w_acc ? QCNT_W'(w_cnt) : QCNT_W'(0))
                               - (w_pop ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // queue payload needs no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (w_acc && (k < int'(w_cnt))) begin
                r_q[r_wr_ptr + QPTR_W'(k)] <= w_res[k];
            end
        end
    end

`ifndef SYNTHESIS
    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // escape progress never reaches the unused code
    a_pend_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc != 2'd3)
        else $error("bad escape progress");

    // end of string returns the parser to its idle state
    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.in_final) |=> (!r_vp && !r_ps && r_pc == PEND_NONE))
        else $error("parse state not cleared after end of string");

    // a final byte other than '&' always closes a pair, so it always causes a result
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.in_final && i_in.in_byte != CH_AMP) |=> (r_count != '0))
        else $error("end of string produced no result");
`endif

endmodule
